/* rtl/core/fqpt_pkg.sv */
// Shared constants, types and helper functions of the per-tensor fake quantiser.
package fqpt_pkg;

  localparam int DIV_QBITS      = 26;
  localparam int DIV_BITS_STAGE = 2;
  localparam int DIV_STAGES     = DIV_QBITS / DIV_BITS_STAGE;

  localparam logic [1:0] CFG_SCALE      = 2'd0;
  localparam logic [1:0] CFG_ZERO_POINT = 2'd1;
  localparam logic [1:0] CFG_QUANT_MIN  = 2'd2;
  localparam logic [1:0] CFG_QUANT_MAX  = 2'd3;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] ZP_RESET    = 32'h0000_0000;
  localparam logic [31:0] QMIN_RESET  = 32'h0000_0000;
  localparam logic [31:0] QMAX_RESET  = 32'h0000_00FF;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] POS_INF     = 32'h7F80_0000;

  localparam logic signed [41:0] SAT_LIMIT = 42'sh100_0000_0000;
  localparam logic [40:0]        SAT_MAG   = 41'h100_0000_0000;

  typedef struct packed {
    logic              sgn;
    logic [23:0]       man;
    logic signed [9:0] exp;
    logic              zero;
    logic              inf;
    logic              nan;
  } fp_unp_t;

  typedef struct packed {
    logic              sgn;
    logic              nan;
    logic              sat;
    logic              zro;
    logic signed [9:0] exp;
    logic              last;
  } div_meta_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) begin
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

  function automatic fp_unp_t unpack(input logic [31:0] b);
    fp_unp_t    u;
    logic [4:0] lz;
    lz     = lzc24({1'b0, b[22:0]});
    u.sgn  = b[31];
    u.zero = (b[30:0] == 31'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (b[30:23] == 8'd0) begin
      u.man = {1'b0, b[22:0]} << lz;
      u.exp = -10'sd126 - signed'({5'd0, lz});
    end else begin
      u.man = {1'b1, b[22:0]};
      u.exp = signed'({2'b00, b[30:23]}) - 10'sd127;
    end
    return u;
  endfunction

endpackage

/* rtl/core/fqpt_if.sv */
// Valid/ready stream interfaces for the element and result channels.
interface fqpt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        last_in;
  modport source (output valid, output value_bits, output last_in, input ready);
  modport sink (input valid, input value_bits, input last_in, output ready);
endinterface

interface fqpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        in_range;
  logic        last_out;
  modport source (output valid, output result_bits, output in_range, output last_out,
                  input ready);
  modport sink (input valid, input result_bits, input in_range, input last_out,
                output ready);
endinterface

/* rtl/core/fake_quantize_per_tensor_top.sv */
// Per-tensor fake quantiser: single-precision divide, round, clamp, dequantise, multiply.
// One element is taken every cycle while input ready is high. The pipeline is built
// around the 26-bit restoring divider, two quotient bits per stage over
// 13 stages, followed by rounding, clamp, integer-to-float conversion and a 24x24
// multiplier. The whole pipeline advances together; when the result register is
// held by the sink, input ready drops and every stage keeps its transaction.
module fake_quantize_per_tensor_top (
  input  logic             clk,
  input  logic             rst_n,
  fqpt_in_if.sink          in_if,
  fqpt_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  logic [31:0] scale_r, zp_r, qmin_r, qmax_r;
  logic        adv;
  fqpt_pkg::fp_unp_t xu, su;
  logic signed [41:0] zp42, qmin42, qmax42;

  // stage 1
  logic                  s1_vld_r;
  fqpt_pkg::div_meta_t   s1_meta_r, s1_meta_nxt;
  logic [23:0]           s1_ma_r, s1_mb_r;
  logic signed [9:0]     s1_ea_r, s1_eb_r;

  // divider pipeline, entry 0 is the set-up stage
  logic                  div_vld_r  [0:fqpt_pkg::DIV_STAGES];
  fqpt_pkg::div_meta_t   div_meta_r [0:fqpt_pkg::DIV_STAGES];
  logic [25:0]           div_rem_r  [0:fqpt_pkg::DIV_STAGES];
  logic [25:0]           div_q_r    [0:fqpt_pkg::DIV_STAGES];
  logic [23:0]           div_mb_r   [0:fqpt_pkg::DIV_STAGES];
  logic                  div_ge;
  fqpt_pkg::div_meta_t   div_meta_nxt;

  // stage 3: float rounding of quotient
  logic                  s3_vld_r;
  fqpt_pkg::div_meta_t   s3_meta_r, s3_meta_nxt;
  logic [23:0]           s3_man_r, s3_man_nxt;
  logic [25:0]           s3_q;
  logic                  s3_up;
  logic [24:0]           s3_sum;

  // stage 4: alignment to integer
  logic                  s4_vld_r;
  fqpt_pkg::div_meta_t   s4_meta_r, s4_meta_nxt;
  logic [39:0]           s4_int_r;
  logic                  s4_rb_r, s4_rest_r;
  logic signed [9:0]     s4_e1;
  logic [63:0]           s4_w;
  logic                  s4_base;

  // stage 5: integer rounding and saturation
  logic                  s5_vld_r, s5_nan_r, s5_last_r;
  logic signed [41:0]    s5_rq_r;
  logic [40:0]           s5_mag;
  logic [41:0]           s5_mag42;

  // stage 6: zero point and range flag
  logic                  s6_vld_r, s6_last_r, s6_mask_r;
  logic signed [41:0]    s6_qv_r, s6_qv_nxt;

  // stage 7: clamp
  logic                  s7_vld_r, s7_last_r, s7_mask_r;
  logic signed [31:0]    s7_cl_r;
  logic signed [41:0]    s7_lo, s7_hi;

  // stage 8: remove zero point
  logic                  s8_vld_r, s8_last_r, s8_mask_r, s8_sgn_r;
  logic [31:0]           s8_mag_r;
  logic signed [32:0]    s8_d, s8_m;

  // stage 9: normalise
  logic                  s9_vld_r, s9_last_r, s9_mask_r, s9_sgn_r, s9_zero_r;
  logic [31:0]           s9_nrm_r;
  logic [5:0]            s9_lz_r, s9_lz;

  // stage 10: round to single precision
  logic                  s10_vld_r, s10_last_r, s10_mask_r, s10_sgn_r, s10_zero_r;
  logic [23:0]           s10_md_r;
  logic [5:0]            s10_ed_r;
  logic                  s10_up;
  logic [24:0]           s10_sum;

  // stage 11: multiply
  logic                  s11_vld_r, s11_last_r, s11_mask_r, s11_sgn_r;
  logic [47:0]           s11_p_r;
  logic signed [9:0]     s11_e_r;
  logic                  s11_spec_r, s11_spec_nxt;
  logic [31:0]           s11_sbits_r, s11_sbits_nxt;

  // stage 12: normalise product
  logic                  s12_vld_r, s12_last_r, s12_mask_r, s12_sgn_r;
  logic [47:0]           s12_pn_r;
  logic [4:0]            s12_sh_r;
  logic [7:0]            s12_bef_r;
  logic                  s12_spec_r, s12_spec_nxt;
  logic [31:0]           s12_sbits_r, s12_sbits_nxt;
  logic signed [9:0]     s12_be, s12_nb;

  // stage 13: denormalise
  logic                  s13_vld_r, s13_last_r, s13_mask_r, s13_sgn_r;
  logic [22:0]           s13_frac_r;
  logic [7:0]            s13_bef_r;
  logic                  s13_g_r, s13_st_r, s13_spec_r;
  logic [31:0]           s13_sbits_r;
  logic [47:0]           s13_ps, s13_lostm;

  // output register
  logic                  out_vld_r, out_rng_r, out_last_r;
  logic [31:0]           out_res_r;
  logic                  o_up;
  logic [30:0]           o_body;

  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid       = out_vld_r;
  assign out_if.result_bits = out_res_r;
  assign out_if.in_range    = out_rng_r;
  assign out_if.last_out    = out_last_r;

  assign zp42   = 42'(signed'(zp_r));
  assign qmin42 = 42'(signed'(qmin_r));
  assign qmax42 = 42'(signed'(qmax_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= fqpt_pkg::SCALE_RESET;
      zp_r    <= fqpt_pkg::ZP_RESET;
      qmin_r  <= fqpt_pkg::QMIN_RESET;
      qmax_r  <= fqpt_pkg::QMAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fqpt_pkg::CFG_SCALE:      scale_r <= cfg_data;
        fqpt_pkg::CFG_ZERO_POINT: zp_r    <= cfg_data;
        fqpt_pkg::CFG_QUANT_MIN:  qmin_r  <= cfg_data;
        fqpt_pkg::CFG_QUANT_MAX:  qmax_r  <= cfg_data;
      endcase
    end
  end

  // stage 1: unpack and classify
  always_comb begin
    xu = fqpt_pkg::unpack(in_if.value_bits);
    su = fqpt_pkg::unpack(scale_r);
    s1_meta_nxt.sgn  = xu.sgn ^ su.sgn;
    s1_meta_nxt.nan  = xu.nan || su.nan || (xu.inf && su.inf) || (su.zero && xu.zero);
    s1_meta_nxt.sat  = !s1_meta_nxt.nan && (xu.inf || (su.zero && !xu.zero));
    s1_meta_nxt.zro  = !s1_meta_nxt.nan && !s1_meta_nxt.sat && (xu.zero || su.inf);
    s1_meta_nxt.exp  = 10'sd0;
    s1_meta_nxt.last = in_if.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r <= s1_meta_nxt;
      s1_ma_r   <= xu.man;
      s1_mb_r   <= su.man;
      s1_ea_r   <= xu.exp;
      s1_eb_r   <= su.exp;
    end
  end

  // stage 2: bring dividend into [divisor, 2*divisor)
  always_comb begin
    div_ge           = s1_ma_r >= s1_mb_r;
    div_meta_nxt     = s1_meta_r;
    div_meta_nxt.exp = s1_ea_r - s1_eb_r - (div_ge ? 10'sd0 : 10'sd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else if (adv) begin
      div_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_meta_r[0] <= div_meta_nxt;
      div_rem_r[0]  <= div_ge ? {2'b00, s1_ma_r} : {1'b0, s1_ma_r, 1'b0};
      div_q_r[0]    <= 26'd0;
      div_mb_r[0]   <= s1_mb_r;
    end
  end

  for (genvar k = 1; k <= fqpt_pkg::DIV_STAGES; k++) begin : g_div
    logic [25:0] dv, r1, r2, r3;
    logic        b1, b2;

    always_comb begin
      dv = {2'b00, div_mb_r[k-1]};
      b1 = div_rem_r[k-1] >= dv;
      r1 = b1 ? div_rem_r[k-1] - dv : div_rem_r[k-1];
      r2 = {r1[24:0], 1'b0};
      b2 = r2 >= dv;
      r3 = b2 ? r2 - dv : r2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[k] <= 1'b0;
      end else if (adv) begin
        div_vld_r[k] <= div_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_meta_r[k] <= div_meta_r[k-1];
        div_rem_r[k]  <= {r3[24:0], 1'b0};
        div_q_r[k]    <= {div_q_r[k-1][23:0], b1, b2};
        div_mb_r[k]   <= div_mb_r[k-1];
      end
    end
  end

  // stage 3: round quotient to single precision
  always_comb begin
    s3_q        = div_q_r[fqpt_pkg::DIV_STAGES];
    s3_up       = s3_q[1] && (s3_q[0] || (div_rem_r[fqpt_pkg::DIV_STAGES] != 26'd0) || s3_q[2]);
    s3_sum      = {1'b0, s3_q[25:2]} + 25'(s3_up);
    s3_meta_nxt = div_meta_r[fqpt_pkg::DIV_STAGES];
    if (s3_sum[24]) begin
      s3_man_nxt      = 24'h80_0000;
      s3_meta_nxt.exp = div_meta_r[fqpt_pkg::DIV_STAGES].exp + 10'sd1;
    end else begin
      s3_man_nxt = s3_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= div_vld_r[fqpt_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_meta_r <= s3_meta_nxt;
      s3_man_r  <= s3_man_nxt;
    end
  end

  // stage 4: align to 24 fractional bits
  always_comb begin
    s4_base         = !s3_meta_r.nan && !s3_meta_r.sat && !s3_meta_r.zro;
    s4_e1           = s3_meta_r.exp + 10'sd1;
    s4_w            = {40'd0, s3_man_r} << s4_e1[5:0];
    s4_meta_nxt     = s3_meta_r;
    s4_meta_nxt.sat = s3_meta_r.sat || (s4_base && (s3_meta_r.exp >= 10'sd40));
    s4_meta_nxt.zro = s3_meta_r.zro || (s4_base && (s3_meta_r.exp < -10'sd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_meta_r <= s4_meta_nxt;
      s4_int_r  <= s4_w[63:24];
      s4_rb_r   <= s4_w[23];
      s4_rest_r <= |s4_w[22:0];
    end
  end

  // stage 5: round to integer, ties to even, and saturate
  always_comb begin
    s5_mag = {1'b0, s4_int_r} + 41'(s4_rb_r && (s4_rest_r || s4_int_r[0]));
    if (s4_meta_r.sat) begin
      s5_mag = fqpt_pkg::SAT_MAG;
    end else if (s4_meta_r.zro) begin
      s5_mag = 41'd0;
    end
    s5_mag42 = {1'b0, s5_mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_nan_r  <= s4_meta_r.nan;
      s5_last_r <= s4_meta_r.last;
      s5_rq_r   <= signed'(s4_meta_r.sgn ? (~s5_mag42 + 42'd1) : s5_mag42);
    end
  end

  // stage 6: add zero point, range flag
  assign s6_qv_nxt = s5_nan_r ? qmin42 : s5_rq_r + zp42;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_qv_r   <= s6_qv_nxt;
      s6_last_r <= s5_last_r;
      s6_mask_r <= !s5_nan_r && (s6_qv_nxt >= qmin42) && (s6_qv_nxt <= qmax42);
    end
  end

  // stage 7: clamp
  always_comb begin
    s7_lo = (s6_qv_r < qmin42) ? qmin42 : s6_qv_r;
    s7_hi = (s7_lo > qmax42) ? qmax42 : s7_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (adv) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_cl_r   <= s7_hi[31:0];
      s7_last_r <= s6_last_r;
      s7_mask_r <= s6_mask_r;
    end
  end

  // stage 8: subtract zero point, take magnitude
  always_comb begin
    s8_d = 33'(s7_cl_r) - 33'(signed'(zp_r));
    s8_m = s8_d[32] ? -s8_d : s8_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (adv) begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_sgn_r  <= s8_d[32];
      s8_mag_r  <= s8_m[31:0];
      s8_last_r <= s7_last_r;
      s8_mask_r <= s7_mask_r;
    end
  end

  // stage 9: leading-zero count and normalise
  assign s9_lz = fqpt_pkg::lzc32(s8_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (adv) begin
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_nrm_r  <= s8_mag_r << s9_lz[4:0];
      s9_lz_r   <= s9_lz;
      s9_zero_r <= (s8_mag_r == 32'd0);
      s9_sgn_r  <= s8_sgn_r;
      s9_last_r <= s8_last_r;
      s9_mask_r <= s8_mask_r;
    end
  end

  // stage 10: round to 24 significant bits
  always_comb begin
    s10_up  = s9_nrm_r[7] && ((|s9_nrm_r[6:0]) || s9_nrm_r[8]);
    s10_sum = {1'b0, s9_nrm_r[31:8]} + 25'(s10_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else if (adv) begin
      s10_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_md_r   <= s10_sum[24] ? 24'h80_0000 : s10_sum[23:0];
      s10_ed_r   <= 6'd31 - s9_lz_r + {5'd0, s10_sum[24]};
      s10_zero_r <= s9_zero_r;
      s10_sgn_r  <= s9_sgn_r;
      s10_last_r <= s9_last_r;
      s10_mask_r <= s9_mask_r;
    end
  end

  // stage 11: multiply by scale, settle special operands
  always_comb begin
    s11_spec_nxt  = 1'b1;
    s11_sbits_nxt = {s10_sgn_r ^ su.sgn, 31'd0};
    priority if (su.nan) begin
      s11_sbits_nxt = scale_r | fqpt_pkg::QNAN_BIT;
    end else if (su.inf) begin
      s11_sbits_nxt = s10_zero_r ? fqpt_pkg::DEFAULT_NAN
                                 : {s10_sgn_r ^ su.sgn, fqpt_pkg::POS_INF[30:0]};
    end else if (su.zero || s10_zero_r) begin
      s11_sbits_nxt = {s10_sgn_r ^ su.sgn, 31'd0};
    end else begin
      s11_spec_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_vld_r <= 1'b0;
    end else if (adv) begin
      s11_vld_r <= s10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_p_r     <= 48'(s10_md_r) * 48'(su.man);
      s11_e_r     <= signed'({4'b0000, s10_ed_r}) + su.exp;
      s11_sgn_r   <= s10_sgn_r ^ su.sgn;
      s11_spec_r  <= s11_spec_nxt;
      s11_sbits_r <= s11_sbits_nxt;
      s11_last_r  <= s10_last_r;
      s11_mask_r  <= s10_mask_r;
    end
  end

  // stage 12: normalise product, overflow and subnormal shift
  always_comb begin
    s12_be        = s11_e_r + 10'sd127 + (s11_p_r[47] ? 10'sd1 : 10'sd0);
    s12_nb        = 10'sd1 - s12_be;
    s12_spec_nxt  = s11_spec_r;
    s12_sbits_nxt = s11_sbits_r;
    if (!s11_spec_r && (s12_be >= 10'sd255)) begin
      s12_spec_nxt  = 1'b1;
      s12_sbits_nxt = {s11_sgn_r, fqpt_pkg::POS_INF[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_vld_r <= 1'b0;
    end else if (adv) begin
      s12_vld_r <= s11_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_pn_r    <= s11_p_r[47] ? s11_p_r : {s11_p_r[46:0], 1'b0};
      s12_sh_r    <= (s12_be <= 10'sd0) ? s12_nb[4:0] : 5'd0;
      s12_bef_r   <= (s12_be <= 10'sd0) ? 8'd0 : s12_be[7:0];
      s12_spec_r  <= s12_spec_nxt;
      s12_sbits_r <= s12_sbits_nxt;
      s12_sgn_r   <= s11_sgn_r;
      s12_last_r  <= s11_last_r;
      s12_mask_r  <= s11_mask_r;
    end
  end

  // stage 13: shift into subnormal range, keep sticky
  always_comb begin
    s13_ps    = s12_pn_r >> s12_sh_r;
    s13_lostm = (48'd1 << s12_sh_r) - 48'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s13_vld_r <= 1'b0;
    end else if (adv) begin
      s13_vld_r <= s12_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_frac_r  <= s13_ps[46:24];
      s13_g_r     <= s13_ps[23];
      s13_st_r    <= (|s13_ps[22:0]) || ((s12_pn_r & s13_lostm) != 48'd0);
      s13_bef_r   <= s12_bef_r;
      s13_spec_r  <= s12_spec_r;
      s13_sbits_r <= s12_sbits_r;
      s13_sgn_r   <= s12_sgn_r;
      s13_last_r  <= s12_last_r;
      s13_mask_r  <= s12_mask_r;
    end
  end

  // output stage: round and pack
  always_comb begin
    o_up   = s13_g_r && (s13_st_r || s13_frac_r[0]);
    o_body = {s13_bef_r, s13_frac_r} + 31'(o_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s13_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r  <= s13_spec_r ? s13_sbits_r : {s13_sgn_r, o_body};
      out_rng_r  <= s13_mask_r;
      out_last_r <= s13_last_r;
    end
  end

  a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[fqpt_pkg::DIV_STAGES] && !div_meta_r[fqpt_pkg::DIV_STAGES].nan &&
    !div_meta_r[fqpt_pkg::DIV_STAGES].sat && !div_meta_r[fqpt_pkg::DIV_STAGES].zro
    |-> div_q_r[fqpt_pkg::DIV_STAGES][fqpt_pkg::DIV_QBITS-1])
    else $error("quotient not normalised");

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> (s5_rq_r <= fqpt_pkg::SAT_LIMIT) && (s5_rq_r >= -fqpt_pkg::SAT_LIMIT))
    else $error("rounded quotient beyond saturation limit");

  a_mask_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s7_vld_r && s7_mask_r |->
      (s7_cl_r >= signed'(qmin_r)) && (s7_cl_r <= signed'(qmax_r)))
    else $error("in-range element clamped outside range");

  a_itof_norm: assert property (@(posedge clk) disable iff (!rst_n)
    s10_vld_r && !s10_zero_r |-> s10_md_r[23])
    else $error("dequantised significand not normalised");

endmodule

/* tb/fqpt_checker.sv */
// Checker for the per-tensor fake quantiser: watches the channels, predicts each result and compares.
module fqpt_checker (
  input  logic        clk,
  input  logic        rst_n,
  fqpt_in_if          in_if,
  fqpt_out_if         out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          n_errors,
  output int          n_pending,
  output int          n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] bits;
    logic        rng;
    logic        last;
  } fq_result_t;

  logic [31:0] scale_q;
  logic [31:0] zp_q;
  logic [31:0] qmin_q;
  logic [31:0] qmax_q;
  fq_result_t  expected_q[$];

  localparam longint SAT = 64'sd1 << 40;

  function automatic real sp_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'd0) begin
      r = real'(b[22:0]) * (2.0 ** (-149));
      if (b[31]) begin
        r = -r;
      end
    end else begin
      r = $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
    end
    return r;
  endfunction

  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0]     d;
    int              e;
    int              s;
    int              ex;
    longint unsigned sig;
    longint unsigned keep;
    longint unsigned rem;
    longint unsigned half;
    d = $realtobits(r);
    e = int'(d[62:52]) - 1023;
    if (d[62:52] == 11'd0) begin
      return {d[63], 31'd0};
    end
    if (d[62:52] == 11'h7FF || e > 127) begin
      return {d[63], fqpt_pkg::POS_INF[30:0]};
    end
    sig = {11'd0, 1'b1, d[51:0]};
    s = (e >= -126) ? 29 : 29 + (-126 - e);
    if (s > 60) begin
      return {d[63], 31'd0};
    end
    keep = sig >> s;
    rem  = sig & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && keep[0])) begin
      keep++;
    end
    if (e >= -126) begin
      ex = e + 127;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        ex++;
      end
      if (ex >= 255) begin
        return {d[63], fqpt_pkg::POS_INF[30:0]};
      end
      return {d[63], 8'(ex), keep[22:0]};
    end
    return {d[63], 31'(keep)};
  endfunction

  function automatic longint round_even_sat(input logic [31:0] qb);
    longint unsigned m;
    longint unsigned t;
    longint unsigned rem;
    longint unsigned half;
    longint          mag;
    int              e;
    int              s;
    m = {40'd0, 1'b1, qb[22:0]};
    e = int'(qb[30:23]) - 127;
    if (qb[30:23] == 8'd0 || e < -1) begin
      mag = 0;
    end else if (e >= 40) begin
      mag = SAT;
    end else if (e >= 23) begin
      mag = longint'(m << (e - 23));
    end else begin
      s = 23 - e;
      t = m >> s;
      rem = m & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && t[0])) begin
        t++;
      end
      mag = longint'(t);
    end
    return qb[31] ? -mag : mag;
  endfunction

  function automatic fq_result_t fake_quantise(input logic [31:0] xb, input logic last);
    fq_result_t  r;
    longint      zp;
    longint      qmin;
    longint      qmax;
    longint      rq;
    longint      qv;
    longint      cl;
    logic        nan_q;
    logic        x_nan;
    logic        s_nan;
    logic        x_inf;
    logic        s_inf;
    logic [31:0] dq;
    zp = longint'(signed'(zp_q));
    qmin = longint'(signed'(qmin_q));
    qmax = longint'(signed'(qmax_q));
    x_nan = (xb[30:23] == 8'hFF) && (xb[22:0] != 0);
    s_nan = (scale_q[30:23] == 8'hFF) && (scale_q[22:0] != 0);
    x_inf = (xb[30:0] == fqpt_pkg::POS_INF[30:0]);
    s_inf = (scale_q[30:0] == fqpt_pkg::POS_INF[30:0]);
    nan_q = 1'b0;
    rq = 0;
    if (scale_q[30:0] == 31'd0) begin
      if (x_nan || xb[30:0] == 31'd0) begin
        nan_q = 1'b1;
      end else begin
        rq = (xb[31] ^ scale_q[31]) ? -SAT : SAT;
      end
    end else if (x_nan || s_nan || (x_inf && s_inf)) begin
      nan_q = 1'b1;
    end else if (x_inf) begin
      rq = (xb[31] ^ scale_q[31]) ? -SAT : SAT;
    end else if (!s_inf) begin
      rq = round_even_sat(real_to_sp(sp_to_real(xb) / sp_to_real(scale_q)));
    end
    if (nan_q) begin
      qv = qmin;
      r.rng = 1'b0;
    end else begin
      qv = rq + zp;
      r.rng = (qmin <= qv) && (qv <= qmax);
    end
    cl = (qv < qmin) ? qmin : qv;
    if (cl > qmax) begin
      cl = qmax;
    end
    dq = real_to_sp(real'(cl - zp));
    if (s_nan) begin
      r.bits = scale_q | fqpt_pkg::QNAN_BIT;
    end else if (s_inf) begin
      r.bits = (dq[30:0] == 31'd0) ? fqpt_pkg::DEFAULT_NAN
                                   : {dq[31] ^ scale_q[31], fqpt_pkg::POS_INF[30:0]};
    end else begin
      r.bits = real_to_sp(sp_to_real(dq) * sp_to_real(scale_q));
    end
    r.last = last;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  initial begin
    n_errors = 0;
    n_results = 0;
  end

  assign n_pending = expected_q.size();

  always @(posedge clk) begin
    fq_result_t w;
    if (!rst_n) begin
      scale_q <= fqpt_pkg::SCALE_RESET;
      zp_q <= fqpt_pkg::ZP_RESET;
      qmin_q <= fqpt_pkg::QMIN_RESET;
      qmax_q <= fqpt_pkg::QMAX_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fqpt_pkg::CFG_SCALE: begin
            scale_q <= cfg_data;
          end
          fqpt_pkg::CFG_ZERO_POINT: begin
            zp_q <= cfg_data;
          end
          fqpt_pkg::CFG_QUANT_MIN: begin
            qmin_q <= cfg_data;
          end
          default: begin
            qmax_q <= cfg_data;
          end
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(fake_quantise(in_if.value_bits, in_if.last_in));
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report("unexpected transaction", out_if.result_bits, 32'hx);
        end else begin
          w = expected_q.pop_front();
          if (out_if.result_bits !== w.bits) begin
            report("result_bits", out_if.result_bits, w.bits);
          end
          if (out_if.in_range !== w.rng) begin
            report("in_range", 32'(out_if.in_range), 32'(w.rng));
          end
          if (out_if.last_out !== w.last) begin
            report("last_out", 32'(out_if.last_out), 32'(w.last));
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// Top of the fake quantiser testbench: clock, reset, stimulus, configuration phases and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        quiet;
  int          n_errors;
  int          n_pending;
  int          n_results;
  int          n_sent;
  int          n_phases;

  fqpt_in_if  in_if ();
  fqpt_out_if out_if ();

  fake_quantize_per_tensor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fqpt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_errors  (n_errors),
    .n_pending (n_pending),
    .n_results (n_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 15);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send(input logic [31:0] v, input logic last);
    logic ok;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.value_bits = v;
    in_if.last_in = last;
    do begin
      #1;
      ok = in_if.ready;
      @(negedge clk);
    end while (!ok);
    in_if.valid = 1'b0;
    n_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (n_pending != 0) begin
      @(negedge clk);
    end
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] scale);
    logic [31:0] v;
    int          ex;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1: begin
      end
      2: begin
        v[30:23] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        if ($urandom_range(0, 1) == 0) begin
          v[22:0] = '0;
        end
      end
      default: begin
        ex = int'(scale[30:23]) + $urandom_range(0, 12) - 3;
        ex = (ex < 1) ? 1 : (ex > 254) ? 254 : ex;
        v[30:23] = 8'(ex);
        if ($urandom_range(0, 3) == 0) begin
          v[15:0] = '0;
        end
      end
    endcase
    return v;
  endfunction

  task automatic run_phase(input logic [31:0] scale, input logic [31:0] zp,
                           input logic [31:0] qmin, input logic [31:0] qmax, input int n);
    drain();
    write_reg(fqpt_pkg::CFG_SCALE, scale);
    write_reg(fqpt_pkg::CFG_ZERO_POINT, zp);
    write_reg(fqpt_pkg::CFG_QUANT_MIN, qmin);
    write_reg(fqpt_pkg::CFG_QUANT_MAX, qmax);
    n_phases++;
    repeat (n) send(pick_value(scale), 1'($urandom_range(0, 15) == 0));
  endtask

  initial begin
    logic [31:0] directed[$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fqpt_pkg::CFG_SCALE;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.value_bits = '0;
    in_if.last_in = 1'b0;
    quiet = 1'b0;
    n_sent = 0;
    n_phases = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000,
                 32'h437F_8000, 32'h4380_0000, 32'h437E_8000, 32'hC040_0000,
                 fqpt_pkg::POS_INF, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h5380_0000, 32'hD380_0000, 32'h4B00_0001, 32'h3EFF_FFFF};
    foreach (directed[i]) begin
      send(directed[i], 1'(i == directed.size() - 1));
    end
    repeat (60) send(pick_value(fqpt_pkg::SCALE_RESET), 1'($urandom_range(0, 15) == 0));

    run_phase(32'h3DCC_CCCD, 32'd128, 32'd0, 32'd255, 70);
    run_phase(32'h3A80_0000, 32'hFFFF_FFFB, 32'hFFFF_FF80, 32'd127, 70);
    run_phase(32'h3F80_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 60);
    run_phase(32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 60);
    run_phase(32'h0000_0000, 32'd3, 32'hFFFF_FFF0, 32'd20, 40);
    run_phase(32'h8000_0000, 32'd0, 32'd0, 32'd255, 30);
    run_phase(32'hBE80_0000, 32'd7, 32'hFFFF_FF80, 32'd127, 60);
    run_phase(fqpt_pkg::POS_INF, 32'd1, 32'd0, 32'd10, 30);
    run_phase(32'h7FA0_0001, 32'd0, 32'd0, 32'd255, 20);
    run_phase(32'h3F80_0000, 32'd0, 32'd100, 32'd50, 40);
    run_phase(32'h0000_0003, 32'hFFFF_FF00, 32'hFFFF_F000, 32'h0000_1000, 50);
    run_phase(32'h7F00_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 40);
    drain();
    quiet = 1'b1;
    run_phase(32'h3C23_D70A, 32'd0, 32'd0, 32'd255, 120);

    drain();
    $display("Sent %0d elements over %0d register settings; %0d results checked.",
             n_sent, n_phases, n_results);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* fake_quantize_per_tensor_top.f */
rtl/core/fqpt_pkg.sv
rtl/core/fqpt_if.sv
rtl/core/fake_quantize_per_tensor_top.sv
tb/fqpt_checker.sv
tb/tb.sv
